@@ sv/i64dmu_pkg.sv @@
// Shared types and constants for the 64-bit divide/modulo unit.
// No dependencies.
`default_nettype none

package i64dmu_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        KIND_UQUO = 2'd0,
        KIND_UREM = 2'd1,
        KIND_SQUO = 2'd2,
        KIND_SREM = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PREP = 2'd1,
        S_DIV  = 2'd2,
        S_FIX  = 2'd3
    } t_state;

endpackage : i64dmu_pkg

`default_nettype wire

@@ sv/int64_divide_modulo_unit_top.sv @@
// 64-bit unsigned/signed divide and modulo, radix-2 restoring, one quotient bit per cycle.
// Depends on i64dmu_pkg.
//
// channel | valid       | ready        | payload
// --------+-------------+--------------+------------------------------------
// in      | i_in_valid  | o_in_ready   | i_kind, i_dividend, i_divisor
// out     | o_out_valid | i_out_ready  | o_result
//
// One item is in work at a time: operand magnitudes are taken first, then the
// shift/subtract loop (one quotient bit each step, set by the 65-bit subtractor),
// then sign fix-up into the output register.
// The output register lets a new item be taken while a result waits.
// Fix-up holds when the output register is full and not being taken.
// Reset clears the controller and the output valid; datapath registers are not reset.
`default_nettype none

module int64_divide_modulo_unit_top
    import i64dmu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_result
);

    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_a, n_a;
    logic [DATA_W-1:0]   r_b, n_b;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_want_rem, n_want_rem;
    logic                r_a_neg, n_a_neg;
    logic                r_b_neg, n_b_neg;
    logic                r_zero, n_zero;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_result, n_result;

    logic                in_fire;
    logic                out_fire;
    logic                fix_fire;
    logic                dec_signed;
    logic                dec_rem;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     diff;
    logic                ge;
    logic [DATA_W-1:0]   fix_val;
    logic                fix_neg;

    // kind decode
    always_comb begin
        unique case (t_kind'(i_kind))
            KIND_UQUO: begin dec_signed = 1'b0; dec_rem = 1'b0; end
            KIND_UREM: begin dec_signed = 1'b0; dec_rem = 1'b1; end
            KIND_SQUO: begin dec_signed = 1'b1; dec_rem = 1'b0; end
            KIND_SREM: begin dec_signed = 1'b1; dec_rem = 1'b1; end
            default:   begin dec_signed = 1'b0; dec_rem = 1'b0; end
        endcase
    end

    // controller outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_fire    = i_in_valid && o_in_ready;
        out_fire   = r_out_valid && i_out_ready;
        fix_fire   = (r_state == S_FIX) && (!r_out_valid || i_out_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_LAST) n_state = S_FIX;
            S_FIX:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        shifted = {r_rem, r_a[DATA_W-1]};
        diff    = shifted - {1'b0, r_b};
        ge      = !diff[DATA_W];
        fix_val = r_want_rem ? r_rem : r_a;
        fix_neg = r_want_rem ? r_a_neg : (r_a_neg ^ r_b_neg);

        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_want_rem  = r_want_rem;
        n_a_neg     = r_a_neg;
        n_b_neg     = r_b_neg;
        n_zero      = r_zero;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        if (out_fire) n_out_valid = 1'b0;

        if (in_fire) begin
            n_a        = i_dividend;
            n_b        = i_divisor;
            n_want_rem = dec_rem;
            n_a_neg    = dec_signed && i_dividend[DATA_W-1];
            n_b_neg    = dec_signed && i_divisor[DATA_W-1];
            n_zero     = (i_divisor == '0);
        end
        if (r_state == S_PREP) begin
            if (r_a_neg) n_a = -r_a;
            if (r_b_neg) n_b = -r_b;
            n_rem = '0;
            n_cnt = '0;
        end
        if (r_state == S_DIV) begin
            n_rem = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            n_a   = {r_a[DATA_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
        end
        if (fix_fire) begin
            if (r_zero)       n_result = '0;
            else if (fix_neg) n_result = -fix_val;
            else              n_result = fix_val;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_want_rem <= n_want_rem;
        r_a_neg    <= n_a_neg;
        r_b_neg    <= n_b_neg;
        r_zero     <= n_zero;
        r_result   <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    a_div_runs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != CNT_LAST) |=> (r_state == S_DIV))
        else $error("divide loop left early");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_zero) |-> (r_rem < r_b))
        else $error("partial remainder not below divisor");

    a_zero_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fix_fire && r_zero) |=> (o_out_valid && o_result == '0))
        else $error("zero divisor gave nonzero result");

endmodule : int64_divide_modulo_unit_top

`default_nettype wire

@@ dv/int64_divide_modulo_unit_checker.sv @@
// Checker for the 64-bit divide/modulo unit: watches both channels, computes the
// expected quotient or remainder per item and compares results in order.
// Depends on i64dmu_pkg.
module int64_divide_modulo_unit_checker
    import i64dmu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DATA_W-1:0] i_result,
    output int                o_mismatches,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DATA_W-1:0] quot_rem_q[$];
    logic [DATA_W-1:0] want_result;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic logic [DATA_W-1:0] divide_or_modulo(
        t_kind kind, logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
        logic              is_signed;
        logic              num_neg;
        logic              den_neg;
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        if (den == '0) begin
            return '0;
        end
        is_signed = (kind == KIND_SQUO) || (kind == KIND_SREM);
        num_neg   = is_signed && num[DATA_W-1];
        den_neg   = is_signed && den[DATA_W-1];
        // most negative value has magnitude 2^63, which fits unsigned
        num_mag   = num_neg ? -num : num;
        den_mag   = den_neg ? -den : den;
        quo       = num_mag / den_mag;
        rem       = num_mag % den_mag;
        if (kind == KIND_UQUO || kind == KIND_SQUO) begin
            return (num_neg != den_neg) ? -quo : quo;
        end
        return num_neg ? -rem : rem;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                quot_rem_q.push_back(divide_or_modulo(t_kind'(i_kind), i_dividend, i_divisor));
            end
            if (i_out_valid && i_out_ready) begin
                if (quot_rem_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no item pending", i_result));
                end else begin
                    want_result = quot_rem_q.pop_front();
                    if (i_result !== want_result) begin
                        report_mismatch($sformatf("result %h, want %h", i_result, want_result));
                    end
                end
            end
        end
        o_outstanding <= quot_rem_q.size();
    end

endmodule : int64_divide_modulo_unit_checker

@@ dv/int64_divide_modulo_unit_top_tb.sv @@
// Testbench top for the 64-bit divide/modulo unit: clock, reset, item stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on i64dmu_pkg, int64_divide_modulo_unit_top and int64_divide_modulo_unit_checker.
module int64_divide_modulo_unit_top_tb
    import i64dmu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ALL_ONES = '1;
    localparam int RANDOM_PER_PHASE = 542;
    localparam int HOLD_CYCLES      = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 80;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [1:0]        i_kind      = '0;
    logic [DATA_W-1:0] i_dividend  = '0;
    logic [DATA_W-1:0] i_divisor   = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_result;

    int mismatches;
    int outstanding;
    int tx_idle_pct   = 15;
    int rx_idle_pct   = 81;
    int results_taken = 0;
    int hold_left     = 0;
    int hold_mark     = -1;
    int stall_cycles  = 0;

    always #10 i_clk = ~i_clk;

    int64_divide_modulo_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    int64_divide_modulo_unit_checker div_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_dividend    (i_dividend),
        .i_divisor     (i_divisor),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // receiver: random ready, plus long hold-offs that back the unit up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_taken <= results_taken + 1;
            end
            if ((results_taken == 40 || results_taken == 1200) && results_taken != hold_mark) begin
                hold_mark   <= results_taken;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input t_kind kind, input logic [DATA_W-1:0] num,
                             input logic [DATA_W-1:0] den);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_dividend <= num;
        i_divisor  <= den;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] val;
        int                shape;
        val   = {$urandom, $urandom};
        shape = $urandom_range(9);
        case (shape)
            4, 5, 6: val = val >> $urandom_range(DATA_W - 1);
            7: begin
                case ($urandom_range(5))
                    0: val = '0;
                    1: val = 64'd1;
                    2: val = ALL_ONES;
                    3: val = MOST_NEG;
                    4: val = MOST_POS;
                    default: val = -DATA_W'($urandom_range(15));
                endcase
            end
            8: val = DATA_W'($urandom_range(15));
            default: ;
        endcase
        return val;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero divisor, every kind
        send_item(KIND_UQUO, ALL_ONES, '0);
        send_item(KIND_UREM, ALL_ONES, '0);
        send_item(KIND_SQUO, MOST_NEG, '0);
        send_item(KIND_SREM, 64'd5, '0);
        // most negative by minus one wraps
        send_item(KIND_SQUO, MOST_NEG, ALL_ONES);
        send_item(KIND_SREM, MOST_NEG, ALL_ONES);
        send_item(KIND_SQUO, MOST_NEG, 64'd1);
        send_item(KIND_SREM, MOST_NEG, 64'd3);
        send_item(KIND_SQUO, MOST_NEG, MOST_NEG);
        send_item(KIND_UQUO, MOST_POS, 64'd1);
        send_item(KIND_UREM, MOST_POS, 64'd2);
        send_item(KIND_UQUO, ALL_ONES, ALL_ONES);
        send_item(KIND_UQUO, ALL_ONES, MOST_NEG);
        send_item(KIND_UREM, ALL_ONES, MOST_NEG);
        send_item(KIND_UQUO, 64'd5, 64'd7);
        send_item(KIND_UREM, 64'd5, 64'd7);
        send_item(KIND_SQUO, -64'd7, 64'd2);
        send_item(KIND_SREM, -64'd7, 64'd2);
        send_item(KIND_SQUO, 64'd7, -64'd2);
        send_item(KIND_SREM, 64'd7, -64'd2);
        send_item(KIND_SQUO, -64'd7, -64'd2);
        send_item(KIND_SREM, '0, 64'd5);
        send_item(KIND_UQUO, 64'd1, ALL_ONES);
        send_item(KIND_SQUO, MOST_POS, ALL_ONES);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 15; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_item(t_kind'($urandom_range(3)), pick_operand(), pick_operand());
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : int64_divide_modulo_unit_top_tb
